[rtl/best_fit_segment_allocator_macros.svh]
// Assertion helpers shared by the checker.
`ifndef BEST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH
`define BEST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, held off while reset is low.
`define BFSA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is low.
`define BFSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bfsa_pkg.sv]
package bfsa_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
    localparam int OFF_W        = 24;
    localparam int LEN_W        = 25;
    localparam int GROW_W       = LEN_W + 1;
    localparam logic [LEN_W-1:0] MAX_CAP = LEN_W'(16777216);
    localparam logic [LEN_W-1:0] MIN_CAP = LEN_W'(2);
    localparam logic [LEN_W-1:0] RST_CAP = LEN_W'(65536);

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_LIMIT   = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [LEN_W-1:0] request_size;
        logic [OFF_W-1:0] release_offset;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic [OFF_W-1:0] segment_offset;
        logic [LEN_W-1:0] segment_size;
        logic [LEN_W-1:0] total_capacity;
        logic [LEN_W-1:0] free_capacity;
    } t_out;

    typedef struct packed {
        logic [OFF_W-1:0] start;
        logic [LEN_W-1:0] len;
        logic             free;
    } t_seg;

    typedef enum logic [2:0] {
        ROW_NONE,
        ROW_WALL,
        ROW_WLEN,
        ROW_OPEN,
        ROW_CLOSE
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] pos;
        t_seg             seg;
    } t_row;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
        logic [OFF_W-1:0] start;
        logic [LEN_W-1:0] len;
        logic             prev_free;
        logic [LEN_W-1:0] prev_len;
        logic             next_free;
        logic [LEN_W-1:0] next_len;
        logic             tail_free;
        logic [OFF_W-1:0] tail_start;
        logic [LEN_W-1:0] tail_len;
    } t_scan;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_GROW,
        S_PLACE,
        S_SPLIT,
        S_MARK,
        S_REL1,
        S_REL2,
        S_REL3,
        S_OUT
    } t_state;

endpackage

[rtl/best_fit_segment_allocator.sv]
// Best-fit segment allocator over a linear region.
// Input channel: i_in_valid / o_in_stall carry one t_in transaction (allocate
// or release). Output channel: o_out_valid / i_out_stall return exactly one
// t_out transaction per input, in order.
// Config channel: i_cfg_valid / o_cfg_ready writes the initial capacity; the
// store is re-initialized at once to one free segment of the clamped size.
// The segment table lives in a row of cells, one entry per cell. A search
// token walks the row one cell per cycle and gathers the search result. Then
// come row operations, one per cycle, where every cell shifts or writes in
// parallel: a split (when the chosen segment is larger than asked) and a
// mark for an allocate, merge steps for a release; then the output register
// is loaded. An allocate that has to grow the region first grows the
// capacity in 1.5x steps, then adds the new free space at the tail.
// One transaction is in flight at a time; the next input can be taken in
// the same cycle that the result appears.
// A finished result sits in the output register; the next input can be
// taken while it waits, but the block holds its following result until the
// receiver drops i_out_stall.
// Reset (synchronous, active low) gives one free segment of 65536 bytes.
module best_fit_segment_allocator (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  bfsa_pkg::t_in         i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output bfsa_pkg::t_out        o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [bfsa_pkg::LEN_W-1:0] i_cfg_data
);
    import bfsa_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [LEN_W-1:0]  r_total, n_total;
    logic [LEN_W-1:0]  r_free, n_free;
    logic              r_cmd;
    logic [LEN_W-1:0]  r_req;
    logic [OFF_W-1:0]  r_where;
    logic [CNT_W-1:0]  r_cnt;
    t_scan             r_sc;
    logic [GROW_W-1:0] r_cap;
    logic [GROW_W-1:0] r_need;
    logic [1:0]        r_st;
    logic [OFF_W-1:0]  r_off;
    logic [LEN_W-1:0]  r_len;
    logic              r_ov;
    t_out              r_out;

    t_row              w_row;
    t_seg              w_seg   [MAX_BLOCKS];
    t_scan             w_carry [MAX_BLOCKS+1];
    logic              w_in_acc;
    logic              w_cfg_wr;
    logic [LEN_W-1:0]  w_cfg_cap;
    logic              w_split;
    logic              w_limit;
    logic [LEN_W-1:0]  w_delta;
    logic [1:0]        w_slots;
    logic              w_grow_full;
    logic [LEN_W-1:0]  w_merged;
    logic              w_grow_more;

    assign w_cfg_wr   = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = (r_state == S_IDLE);
    // Config wins over a same-cycle input transaction.
    assign o_in_stall = (r_state != S_IDLE) || i_cfg_valid;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    // Clamp the configured capacity into the legal range.
    assign w_cfg_cap = (i_cfg_data < MIN_CAP) ? MIN_CAP :
                       (i_cfg_data > MAX_CAP) ? MAX_CAP : i_cfg_data;

    assign w_split     = r_sc.len > r_req;
    assign w_limit     = r_cap > GROW_W'(MAX_CAP);
    assign w_delta     = r_cap[LEN_W-1:0] - r_total;
    assign w_slots     = {1'b0, !r_sc.tail_free} +
                         {1'b0, ((GROW_W'(r_sc.tail_free ? r_sc.tail_len : '0) +
                                  GROW_W'(w_delta)) > GROW_W'(r_req))};
    assign w_grow_full = ((CNT_W+1)'(r_count) + (CNT_W+1)'(w_slots)) >
                         (CNT_W+1)'(MAX_BLOCKS);
    assign w_merged    = r_sc.len + (r_sc.next_free ? r_sc.next_len : '0);
    assign w_grow_more = (r_cap < r_need) && (r_cap <= GROW_W'(MAX_CAP));

    // Row of cells; the search token enters empty at cell 0.
    assign w_carry[0] = '0;

    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        t_seg w_l, w_r;
        if (g == 0) begin : g_l0
            assign w_l = '0;
        end else begin : g_ln
            assign w_l = w_seg[g-1];
        end
        if (g == MAX_BLOCKS - 1) begin : g_rl
            assign w_r = '0;
        end else begin : g_rn
            assign w_r = w_seg[g+1];
        end
        bfsa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_count (r_count),
            .i_cmd   (r_cmd),
            .i_req   (r_req),
            .i_where (r_where),
            .i_row   (w_row),
            .i_left  (w_l),
            .i_right (w_r),
            .i_carry (w_carry[g]),
            .o_carry (w_carry[g+1]),
            .o_seg   (w_seg[g])
        );
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_in_acc) n_state = S_SCAN;
            S_SCAN:   if (r_cnt == CNT_W'(MAX_BLOCKS)) n_state = S_DECIDE;
            S_DECIDE: begin
                if (r_cmd == CMD_RELEASE) begin
                    n_state = r_sc.found ? S_REL1 : S_OUT;
                end else if (!r_sc.found) begin
                    n_state = S_GROW;
                end else if (w_split && r_count >= CNT_W'(MAX_BLOCKS)) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_SPLIT;
                end
            end
            S_GROW:   if (!w_grow_more) n_state = S_PLACE;
            S_PLACE:  n_state = (w_limit || w_grow_full) ? S_OUT : S_SPLIT;
            S_SPLIT:  n_state = S_MARK;
            S_MARK:   n_state = S_OUT;
            S_REL1:   n_state = S_REL2;
            S_REL2:   n_state = S_REL3;
            S_REL3:   n_state = S_OUT;
            S_OUT:    if (!r_ov || !i_out_stall) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Row operations and table totals.
    always_comb begin
        w_row   = '{op: ROW_NONE, pos: '0, seg: '0};
        n_count = r_count;
        n_total = r_total;
        n_free  = r_free;
        unique case (r_state)
            S_IDLE: begin
                if (w_cfg_wr) begin
                    w_row   = '{op: ROW_WALL, pos: '0,
                                seg: '{start: '0, len: w_cfg_cap, free: 1'b1}};
                    n_count = CNT_W'(1);
                    n_total = w_cfg_cap;
                    n_free  = w_cfg_cap;
                end
            end
            S_DECIDE: begin
                if (r_cmd == CMD_RELEASE && r_sc.found) n_free = r_free + r_sc.len;
            end
            S_PLACE: begin
                if (!w_limit && !w_grow_full) begin
                    if (r_sc.tail_free) begin
                        w_row = '{op: ROW_WLEN, pos: IDX_W'(r_count - CNT_W'(1)),
                                  seg: '{start: '0, len: r_sc.tail_len + w_delta,
                                         free: 1'b1}};
                    end else begin
                        w_row   = '{op: ROW_WALL, pos: IDX_W'(r_count),
                                    seg: '{start: r_total[OFF_W-1:0], len: w_delta,
                                           free: 1'b1}};
                        n_count = r_count + CNT_W'(1);
                    end
                    n_total = r_cap[LEN_W-1:0];
                    n_free  = r_free + w_delta;
                end
            end
            S_SPLIT: begin
                if (w_split) begin
                    w_row   = '{op: ROW_OPEN, pos: r_sc.idx + IDX_W'(1),
                                seg: '{start: r_sc.start + r_req[OFF_W-1:0],
                                       len: r_sc.len - r_req, free: 1'b1}};
                    n_count = r_count + CNT_W'(1);
                end
            end
            S_MARK: begin
                w_row  = '{op: ROW_WALL, pos: r_sc.idx,
                           seg: '{start: r_sc.start, len: r_req, free: 1'b0}};
                n_free = r_free - r_req;
            end
            S_REL1: begin
                if (r_sc.prev_free) begin
                    w_row = '{op: ROW_WLEN, pos: r_sc.idx - IDX_W'(1),
                              seg: '{start: '0, len: r_sc.prev_len + w_merged, free: 1'b1}};
                end else begin
                    w_row = '{op: ROW_WLEN, pos: r_sc.idx,
                              seg: '{start: '0, len: w_merged, free: 1'b1}};
                end
            end
            S_REL2: begin
                // Drop the released entry into its left neighbor, or absorb the right one.
                if (r_sc.prev_free) begin
                    w_row   = '{op: ROW_CLOSE, pos: r_sc.idx, seg: '0};
                    n_count = r_count - CNT_W'(1);
                end else if (r_sc.next_free) begin
                    w_row   = '{op: ROW_CLOSE, pos: r_sc.idx + IDX_W'(1), seg: '0};
                    n_count = r_count - CNT_W'(1);
                end
            end
            S_REL3: begin
                if (r_sc.prev_free && r_sc.next_free) begin
                    w_row   = '{op: ROW_CLOSE, pos: r_sc.idx, seg: '0};
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= CNT_W'(1);
            r_total <= RST_CAP;
            r_free  <= RST_CAP;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_total <= n_total;
            r_free  <= n_free;
            if (r_ov && !i_out_stall) r_ov <= 1'b0;
            if (r_state == S_OUT && n_state == S_IDLE) begin
                r_ov <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && n_state == S_IDLE) begin
            r_out <= '{status: r_st, segment_offset: r_off, segment_size: r_len,
                       total_capacity: r_total, free_capacity: r_free};
        end
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_cmd   <= i_in_data.cmd;
                    r_req   <= (i_in_data.request_size == '0) ? LEN_W'(1)
                                                              : i_in_data.request_size;
                    r_where <= i_in_data.release_offset;
                    r_cnt   <= '0;
                end
            end
            S_SCAN: begin
                r_cnt <= r_cnt + CNT_W'(1);
                r_sc  <= w_carry[MAX_BLOCKS];
            end
            S_DECIDE: begin
                if (r_cmd == CMD_RELEASE) begin
                    r_st  <= r_sc.found ? ST_OK : ST_UNKNOWN;
                    r_off <= r_where;
                    r_len <= r_sc.found ? r_sc.len : '0;
                end else if (!r_sc.found) begin
                    r_cap  <= GROW_W'(r_total);
                    r_need <= GROW_W'(r_total) + GROW_W'(r_req) -
                              GROW_W'(r_sc.tail_free ? r_sc.tail_len : '0);
                end else begin
                    r_st  <= ST_FULL;
                    r_off <= '0;
                    r_len <= '0;
                end
            end
            S_GROW: begin
                if (w_grow_more) r_cap <= r_cap + (r_cap >> 1);
            end
            S_PLACE: begin
                r_off <= '0;
                r_len <= '0;
                if (w_limit) begin
                    r_st <= ST_LIMIT;
                end else if (w_grow_full) begin
                    r_st <= ST_FULL;
                end else if (r_sc.tail_free) begin
                    r_sc.idx <= IDX_W'(r_count - CNT_W'(1));
                    r_sc.start <= r_sc.tail_start;
                    r_sc.len <= r_sc.tail_len + w_delta;
                end else begin
                    r_sc.idx <= IDX_W'(r_count);
                    r_sc.start <= r_total[OFF_W-1:0];
                    r_sc.len <= w_delta;
                end
            end
            S_MARK: begin
                r_st  <= ST_OK;
                r_off <= r_sc.start;
                r_len <= r_req;
            end
            default: begin
            end
        endcase
    end

endmodule

[rtl/bfsa_cell.sv]
module bfsa_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [bfsa_pkg::IDX_W-1:0] i_idx,
    input  logic [bfsa_pkg::CNT_W-1:0] i_count,
    input  logic                   i_cmd,
    input  logic [bfsa_pkg::LEN_W-1:0] i_req,
    input  logic [bfsa_pkg::OFF_W-1:0] i_where,
    input  bfsa_pkg::t_row         i_row,
    input  bfsa_pkg::t_seg         i_left,
    input  bfsa_pkg::t_seg         i_right,
    input  bfsa_pkg::t_scan        i_carry,
    output bfsa_pkg::t_scan        o_carry,
    output bfsa_pkg::t_seg         o_seg
);
    import bfsa_pkg::*;

    t_seg             r_seg;
    t_scan            r_carry;
    t_scan            n_carry;
    logic [CNT_W-1:0] w_idx;
    logic             w_valid;
    logic             w_next_valid;

    assign w_idx        = CNT_W'(i_idx);
    assign w_valid      = w_idx < i_count;
    assign w_next_valid = (w_idx + CNT_W'(1)) < i_count;
    assign o_seg        = r_seg;
    assign o_carry      = r_carry;

    // Fold this entry into the running search result.
    always_comb begin
        n_carry = i_carry;
        if (w_valid && (w_idx + CNT_W'(1)) == i_count) begin
            n_carry.tail_free  = r_seg.free;
            n_carry.tail_start = r_seg.start;
            n_carry.tail_len   = r_seg.len;
        end
        if (i_cmd == CMD_ALLOC) begin
            if (w_valid && r_seg.free && r_seg.len >= i_req &&
                (!i_carry.found || r_seg.len < i_carry.len)) begin
                n_carry.found = 1'b1;
                n_carry.idx   = i_idx;
                n_carry.start = r_seg.start;
                n_carry.len   = r_seg.len;
            end
        end else begin
            if (w_valid && !r_seg.free && r_seg.start == i_where && !i_carry.found) begin
                n_carry.found     = 1'b1;
                n_carry.idx       = i_idx;
                n_carry.start     = r_seg.start;
                n_carry.len       = r_seg.len;
                n_carry.prev_free = (i_idx != '0) && i_left.free;
                n_carry.prev_len  = i_left.len;
                n_carry.next_free = w_next_valid && i_right.free;
                n_carry.next_len  = i_right.len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry <= n_carry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg <= '{start: '0, len: RST_CAP, free: 1'b1};
        end else begin
            unique case (i_row.op)
                ROW_WALL: begin
                    if (i_idx == i_row.pos) r_seg <= i_row.seg;
                end
                ROW_WLEN: begin
                    if (i_idx == i_row.pos) begin
                        r_seg.len  <= i_row.seg.len;
                        r_seg.free <= i_row.seg.free;
                    end
                end
                ROW_OPEN: begin
                    if (i_idx > i_row.pos) r_seg <= i_left;
                    else if (i_idx == i_row.pos) r_seg <= i_row.seg;
                end
                ROW_CLOSE: begin
                    if (i_idx >= i_row.pos) r_seg <= i_right;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

[rtl/bfsa_checker.sv]
`include "best_fit_segment_allocator_macros.svh"

module bfsa_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input bfsa_pkg::t_out        o_out_data,
    input logic                  i_cfg_valid
);
    import bfsa_pkg::*;

    `BFSA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_data), "stalled result changed")
    `BFSA_ASSERT_NOW(a_free_le_total, i_clk, i_rst_n, o_out_valid,
        o_out_data.free_capacity <= o_out_data.total_capacity, "free above total")
    `BFSA_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n,
        o_out_valid && (o_out_data.status == ST_FULL || o_out_data.status == ST_LIMIT),
        o_out_data.segment_offset == '0 && o_out_data.segment_size == '0,
        "failed allocate returned a segment")
    `BFSA_ASSERT_NOW(a_unknown_zero, i_clk, i_rst_n,
        o_out_valid && o_out_data.status == ST_UNKNOWN,
        o_out_data.segment_size == '0, "unknown release returned a size")
    `BFSA_ASSERT_NOW(a_cfg_blocks_in, i_clk, i_rst_n, i_cfg_valid,
        o_in_stall, "input taken during a config write")

endmodule

bind best_fit_segment_allocator bfsa_checker u_bfsa_checker (.*);
